>>> rtl/nsc_pkg.sv
`timescale 1ns / 1ps
package nsc_pkg;

	// sentence length limit, in characters counted from the dollar sign
	localparam int unsigned MAX_SENTENCE = 128;

	localparam logic [7:0] CHAR_DOLLAR  = 8'h24;
	localparam logic [7:0] CHAR_STAR    = 8'h2A;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_0       = 8'h30;
	localparam logic [7:0] CHAR_9       = 8'h39;
	localparam logic [7:0] CHAR_UA      = 8'h41;
	localparam logic [7:0] CHAR_UF      = 8'h46;
	localparam logic [7:0] CHAR_LA      = 8'h61;
	localparam logic [7:0] CHAR_LF      = 8'h66;

	// first character after the dollar sign that is payload
	localparam logic [7:0] PAYLOAD_START = 8'd3;

	// configuration register indexes
	localparam logic CFG_PAUSED = 1'b0;
	localparam logic CFG_TALKER = 1'b1;

	localparam logic [15:0] TALKER_RESET = 16'h4750;

	// queue between classifier and sentence engine
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// one classified character
	typedef struct packed {
		logic [7:0] ch;
		logic       paused;
		logic       is_dollar;
		logic       is_newline;
		logic       is_star;
		logic       is_hex;
		logic [3:0] hex_val;
	} item_t;

endpackage

>>> rtl/nsc_front.sv
`timescale 1ns / 1ps
module nsc_front (
	input  logic           rx_valid,
	output logic           rx_stall,
	input  logic [7:0]     rx_byte,
	input  logic           paused,
	input  logic           queue_full,
	output logic           push,
	output nsc_pkg::item_t push_item
);
	import nsc_pkg::*;

	logic is_dec;
	logic is_upper;
	logic is_lower;

	assign rx_stall = queue_full;
	assign push     = rx_valid && !queue_full;

	assign is_dec   = (rx_byte >= CHAR_0)  && (rx_byte <= CHAR_9);
	assign is_upper = (rx_byte >= CHAR_UA) && (rx_byte <= CHAR_UF);
	assign is_lower = (rx_byte >= CHAR_LA) && (rx_byte <= CHAR_LF);

	always_comb begin
		push_item.ch         = rx_byte;
		push_item.paused     = paused;
		push_item.is_dollar  = (rx_byte == CHAR_DOLLAR);
		push_item.is_newline = (rx_byte == CHAR_NEWLINE);
		push_item.is_star    = (rx_byte == CHAR_STAR);
		push_item.is_hex     = is_dec || is_upper || is_lower;
		// letters: low nibble plus nine gives 10..15
		if (is_dec) begin
			push_item.hex_val = rx_byte[3:0];
		end else begin
			push_item.hex_val = rx_byte[3:0] + 4'd9;
		end
	end

endmodule

>>> rtl/nsc_queue.sv
`timescale 1ns / 1ps
module nsc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  nsc_pkg::item_t push_item,
	output logic           full,
	input  logic           pop,
	output logic           empty,
	output nsc_pkg::item_t head
);
	import nsc_pkg::*;

	item_t               mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   count_q;

	assign full  = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> rtl/nsc_back.sv
`timescale 1ns / 1ps
module nsc_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [15:0]    talker_prefix,
	input  logic           queue_empty,
	input  nsc_pkg::item_t head,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     out_byte,
	output logic           is_payload,
	output logic           sentence_done,
	output logic           checksum_ok,
	output logic [7:0]     payload_length,
	output logic           overflow
);
	import nsc_pkg::*;

	// sentence state
	logic [7:0]  char_index_q;
	logic [7:0]  xor_sum_q;
	logic        star_seen_q;
	logic [15:0] hex_value_q;
	logic        hex_active_q;
	logic        prefix_match_q;
	logic        too_long_q;
	logic [7:0]  payload_count_q;

	logic [7:0]  char_index_d;
	logic [7:0]  xor_sum_d;
	logic        star_seen_d;
	logic [15:0] hex_value_d;
	logic        hex_active_d;
	logic        prefix_match_d;
	logic        too_long_d;
	logic [7:0]  payload_count_d;

	logic        payload_d;
	logic        done_d;
	logic        ok_d;
	logic [7:0]  len_d;
	logic        ovf_d;

	// output register
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        is_payload_q;
	logic        done_q;
	logic        ok_q;
	logic [7:0]  len_q;
	logic        ovf_q;

	assign pop = !queue_empty && (!out_valid_q || !out_stall);

	always_comb begin
		char_index_d    = char_index_q;
		xor_sum_d       = xor_sum_q;
		star_seen_d     = star_seen_q;
		hex_value_d     = hex_value_q;
		hex_active_d    = hex_active_q;
		prefix_match_d  = prefix_match_q;
		too_long_d      = too_long_q;
		payload_count_d = payload_count_q;
		payload_d       = 1'b0;
		done_d          = 1'b0;
		ok_d            = 1'b0;
		len_d           = '0;
		ovf_d           = 1'b0;

		if (!head.paused) begin
			if (head.is_newline) begin
				if (char_index_q != '0) begin
					done_d = 1'b1;
					ok_d   = prefix_match_q && star_seen_q && !too_long_q &&
					         (hex_value_q == {8'h00, xor_sum_q});
					len_d  = payload_count_q;
					ovf_d  = too_long_q;
					char_index_d    = '0;
					xor_sum_d       = '0;
					star_seen_d     = 1'b0;
					hex_value_d     = '0;
					hex_active_d    = 1'b0;
					prefix_match_d  = 1'b0;
					too_long_d      = 1'b0;
					payload_count_d = '0;
				end
			end else if (head.is_dollar) begin
				char_index_d    = 8'd1;
				xor_sum_d       = '0;
				star_seen_d     = 1'b0;
				hex_value_d     = '0;
				hex_active_d    = 1'b0;
				prefix_match_d  = 1'b0;
				too_long_d      = 1'b0;
				payload_count_d = '0;
			end else if (char_index_q != '0) begin
				if (char_index_q >= 8'(MAX_SENTENCE)) begin
					too_long_d = 1'b1;
				end else begin
					if (char_index_q == 8'd1) begin
						prefix_match_d = (head.ch == talker_prefix[15:8]);
					end else if (char_index_q == 8'd2) begin
						prefix_match_d = prefix_match_q && (head.ch == talker_prefix[7:0]);
					end
					if (head.is_star) begin
						star_seen_d  = 1'b1;
						hex_active_d = 1'b1;
						hex_value_d  = '0;
					end else if (star_seen_q) begin
						if (hex_active_q && head.is_hex) begin
							hex_value_d = {hex_value_q[11:0], head.hex_val};
						end else begin
							hex_active_d = 1'b0;
						end
					end else begin
						xor_sum_d = xor_sum_q ^ head.ch;
						if (char_index_q >= PAYLOAD_START) begin
							payload_d       = 1'b1;
							payload_count_d = payload_count_q + 1'b1;
						end
					end
					char_index_d = char_index_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_index_q    <= '0;
			xor_sum_q       <= '0;
			star_seen_q     <= 1'b0;
			hex_value_q     <= '0;
			hex_active_q    <= 1'b0;
			prefix_match_q  <= 1'b0;
			too_long_q      <= 1'b0;
			payload_count_q <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (pop) begin
				char_index_q    <= char_index_d;
				xor_sum_q       <= xor_sum_d;
				star_seen_q     <= star_seen_d;
				hex_value_q     <= hex_value_d;
				hex_active_q    <= hex_active_d;
				prefix_match_q  <= prefix_match_d;
				too_long_q      <= too_long_d;
				payload_count_q <= payload_count_d;
				out_valid_q     <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_byte_q   <= head.ch;
			is_payload_q <= payload_d;
			done_q       <= done_d;
			ok_q         <= ok_d;
			len_q        <= len_d;
			ovf_q        <= ovf_d;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = out_byte_q;
	assign is_payload     = is_payload_q;
	assign sentence_done  = done_q;
	assign checksum_ok    = ok_q;
	assign payload_length = len_q;
	assign overflow       = ovf_q;

endmodule

>>> rtl/nmea_sentence_checksum_framer_core.sv
`timescale 1ns / 1ps
// path: an accepted character is written into the queue at acceptance, then the sentence engine
// moves it into the output register; a stalled output can hold it in the queue in between
// throughput: one character per cycle while neither out_stall nor a full queue holds the flow
// reset: arst_n clears the queue, the sentence state and the output valid;
// talker prefix returns to "GP" and pause is off
module nmea_sentence_checksum_framer_core (
	input  logic        clk,
	input  logic        arst_n,
	// receive character channel
	input  logic        rx_valid,
	output logic        rx_stall,
	input  logic [7:0]  rx_byte,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        is_payload,
	output logic        sentence_done,
	output logic        checksum_ok,
	output logic [7:0]  payload_length,
	output logic        overflow,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import nsc_pkg::*;

	// configuration registers
	logic        paused_q;
	logic [15:0] talker_prefix_q;

	// front to queue
	logic  push;
	item_t push_item;
	logic  queue_full;

	// queue to back
	logic  pop;
	logic  queue_empty;
	item_t head;

	// config writes are always accepted; cfg_ready is tied high
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			paused_q        <= 1'b0;
			talker_prefix_q <= TALKER_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_PAUSED: paused_q        <= cfg_data[0];
				CFG_TALKER: talker_prefix_q <= cfg_data;
				default:    paused_q        <= paused_q;
			endcase
		end
	end

	// front: takes the character transfer and tags it with its class
	nsc_front u_front (
		.rx_valid   (rx_valid),
		.rx_stall   (rx_stall),
		.rx_byte    (rx_byte),
		.paused     (paused_q),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// short queue so that the two sides stall independently
	nsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.empty     (queue_empty),
		.head      (head)
	);

	// back: sentence state, checksum verdict and result register
	nsc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.talker_prefix  (talker_prefix_q),
		.queue_empty    (queue_empty),
		.head           (head),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_byte       (out_byte),
		.is_payload     (is_payload),
		.sentence_done  (sentence_done),
		.checksum_ok    (checksum_ok),
		.payload_length (payload_length),
		.overflow       (overflow)
	);

endmodule
